>>> rtl/cht_pkg.sv
// Shared types and constants for the climate hysteresis and CO2 trend block.
package cht_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_NM,
        ST_NN,
        ST_DD,
        ST_BOT,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_DIVS,
        ST_DIVW
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam logic ACT_MEAS   = 1'b0;
    localparam logic ACT_MANUAL = 1'b1;

    localparam logic [7:0] REG_CO2_ON   = 8'd0;
    localparam logic [7:0] REG_CO2_OFF  = 8'd1;
    localparam logic [7:0] REG_TEMP_ON  = 8'd2;
    localparam logic [7:0] REG_TEMP_OFF = 8'd3;

    localparam logic        [13:0] CO2_ON_RST   = 14'd900;
    localparam logic        [13:0] CO2_OFF_RST  = 14'd600;
    localparam logic signed [14:0] TEMP_ON_RST  = 15'sd2500;
    localparam logic signed [14:0] TEMP_OFF_RST = 15'sd2200;

    localparam int MIN_SAMPLES = 5;
    localparam int Q_BITS      = 17;

endpackage

>>> rtl/cht_if.sv
// Handshake interfaces for measurement items, result items and register writes.
interface cht_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic        [13:0] co2_ppm;
    logic signed [14:0] temp_centi;
    logic               set_vent_valid;
    logic               set_vent_value;
    logic               set_ac_valid;
    logic               set_ac_value;
    modport source (output valid, action, co2_ppm, temp_centi, set_vent_valid,
                    set_vent_value, set_ac_valid, set_ac_value, input ready);
    modport sink (input valid, action, co2_ppm, temp_centi, set_vent_valid,
                  set_vent_value, set_ac_valid, set_ac_value, output ready);
endinterface

interface cht_out_if;
    logic        valid;
    logic        ready;
    logic        vent_on;
    logic        ac_on;
    logic        prediction_valid;
    logic [15:0] predicted_co2;
    modport source (output valid, vent_on, ac_on, prediction_valid, predicted_co2,
                    input ready);
    modport sink (input valid, vent_on, ac_on, prediction_valid, predicted_co2,
                  output ready);
endinterface

interface cht_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/climate_hysteresis_co2_trend_top.sv
// Top level of the room climate controller with hysteresis flags and CO2 trend forecast.
// Each transaction updates the ventilation and AC flags by hysteresis (or by manual
// override) and returns one result. With fewer than five stored samples the result is
// ready in the cycle after the input is taken. Otherwise a least-squares forecast is formed:
// the sample memory is walked at one entry a cycle, seven products then go through one shared
// registered multiplier, and a restoring divider yields one quotient bit a cycle; the divider
// skips its iterations when the forecast is clamped at zero or saturated. The block takes no
// new transaction while a forecast is being computed nor while an unread result is held.
module climate_hysteresis_co2_trend_top #(
    parameter int WINDOW = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cht_in_if.sink    i_in,
    cht_out_if.source o_out,
    cht_cfg_if.sink   i_cfg
);
    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SYW   = 14 + CW;
    localparam int QW    = SYW + CW;
    localparam int NW    = 2 * CW;
    localparam int DW    = 4 * CW;
    localparam int BOTW  = 5 * CW;
    localparam int NUMW  = SYW + 2 * CW + 1;
    localparam int KW    = 2 * CW + 4;
    localparam int TA    = SYW + DW;
    localparam int TB    = NUMW + KW;
    localparam int TOPW  = ((TA > TB) ? TA : TB) + 2;
    localparam int MAW   = NUMW + 1;
    localparam int MBW   = ((DW > KW) ? DW : KW) + 1;
    localparam int PW    = MAW + MBW;
    localparam int SW    = AW + 2;

    cht_pkg::t_state r_state, n_state;

    logic        [13:0] r_co2_on, r_co2_off;
    logic signed [14:0] r_temp_on, r_temp_off;
    logic               r_vent, r_ac;
    logic [CW-1:0]      r_cnt, r_n, r_k;
    logic [AW-1:0]      r_wp, r_ra;
    logic [SYW-1:0]     r_sy;
    logic [QW-1:0]      r_q;
    logic [NW-1:0]      r_sx, r_nn;
    logic [DW-1:0]      r_d;
    logic [BOTW-1:0]    r_bot;
    logic signed [NUMW-1:0] r_num;
    logic signed [TOPW-1:0] r_top;
    logic               r_ov, r_opv, r_ovent, r_oac;
    logic [15:0]        r_opc;

    logic               accept, meas, vent_nx, ac_nx;
    logic [CW-1:0]      cnt_nx;
    logic [AW-1:0]      wp_nx;
    logic [SW-1:0]      start_s;
    logic [13:0]        rdata;
    logic [SYW-1:0]     sy_new;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    logic [NW-1:0]      nnc;
    logic [KW-1:0]      kdiff, kval;
    logic               div_start;
    cht_pkg::t_div_stat div_stat;
    logic [15:0]        div_q;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == cht_pkg::ST_IDLE) && (!r_ov || o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign meas        = i_in.action == cht_pkg::ACT_MEAS;

    always_comb begin
        vent_nx = r_vent;
        ac_nx   = r_ac;
        if (meas) begin
            if (!r_vent) begin
                if (i_in.co2_ppm > r_co2_on) begin
                    vent_nx = 1'b1;
                end
            end else if (i_in.co2_ppm < r_co2_off) begin
                vent_nx = 1'b0;
            end
            if (!r_ac) begin
                if (i_in.temp_centi > r_temp_on) begin
                    ac_nx = 1'b1;
                end
            end else if (i_in.temp_centi <= r_temp_off) begin
                ac_nx = 1'b0;
            end
        end else begin
            if (i_in.set_vent_valid) begin
                vent_nx = i_in.set_vent_value;
            end
            if (i_in.set_ac_valid) begin
                ac_nx = i_in.set_ac_value;
            end
        end
    end

    always_comb begin
        cnt_nx = r_cnt;
        wp_nx  = r_wp;
        if (meas) begin
            if (r_cnt < CW'(WINDOW)) begin
                cnt_nx = r_cnt + 1'b1;
            end
            wp_nx = (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
        end
        start_s = SW'(wp_nx) + SW'(WINDOW) - SW'(cnt_nx);
        if (start_s >= SW'(WINDOW)) begin
            start_s = start_s - SW'(WINDOW);
        end
    end

    assign sy_new = r_sy + SYW'(rdata);
    assign nnc    = mul_p[NW-1:0] + NW'(r_n);
    assign kdiff  = KW'(r_nn - r_sx);
    assign kval   = (kdiff << 3) + (kdiff << 2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::ST_IDLE: begin
                if (accept && (cnt_nx >= CW'(cht_pkg::MIN_SAMPLES))) begin
                    n_state = cht_pkg::ST_WALK;
                end
            end
            cht_pkg::ST_WALK: begin
                if (r_k == r_n) begin
                    n_state = cht_pkg::ST_NM;
                end
            end
            cht_pkg::ST_NM:   n_state = cht_pkg::ST_NN;
            cht_pkg::ST_NN:   n_state = cht_pkg::ST_DD;
            cht_pkg::ST_DD:   n_state = cht_pkg::ST_BOT;
            cht_pkg::ST_BOT:  n_state = cht_pkg::ST_T1;
            cht_pkg::ST_T1:   n_state = cht_pkg::ST_T2;
            cht_pkg::ST_T2:   n_state = cht_pkg::ST_T3;
            cht_pkg::ST_T3:   n_state = cht_pkg::ST_T4;
            cht_pkg::ST_T4:   n_state = cht_pkg::ST_DIVS;
            cht_pkg::ST_DIVS: n_state = cht_pkg::ST_DIVW;
            cht_pkg::ST_DIVW: begin
                if (div_stat.done) begin
                    n_state = cht_pkg::ST_IDLE;
                end
            end
            default: n_state = cht_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            cht_pkg::ST_NM: begin
                mul_a = MAW'($signed({1'b0, r_n}));
                mul_b = MBW'($signed({1'b0, r_n - 1'b1}));
            end
            cht_pkg::ST_NN: begin
                mul_a = MAW'($signed({1'b0, nnc}));
                mul_b = MBW'($signed({1'b0, nnc - 1'b1}));
            end
            cht_pkg::ST_DD: begin
                mul_a = MAW'($signed({1'b0, mul_p[DW-1:0]}));
                mul_b = MBW'($signed({1'b0, r_n}));
            end
            cht_pkg::ST_BOT: begin
                mul_a = MAW'($signed({1'b0, r_sy}));
                mul_b = MBW'($signed({1'b0, r_sx}));
            end
            cht_pkg::ST_T1: begin
                mul_a = MAW'($signed({1'b0, r_q}));
                mul_b = MBW'($signed({1'b0, r_n}));
            end
            cht_pkg::ST_T2: begin
                mul_a = MAW'($signed({1'b0, r_sy}));
                mul_b = MBW'($signed({1'b0, r_d}));
            end
            cht_pkg::ST_T3: begin
                mul_a = MAW'(r_num);
                mul_b = MBW'($signed({1'b0, kval}));
            end
            cht_pkg::ST_DIVS: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cht_pkg::ST_IDLE;
            r_co2_on   <= cht_pkg::CO2_ON_RST;
            r_co2_off  <= cht_pkg::CO2_OFF_RST;
            r_temp_on  <= cht_pkg::TEMP_ON_RST;
            r_temp_off <= cht_pkg::TEMP_OFF_RST;
            r_vent     <= 1'b0;
            r_ac       <= 1'b0;
            r_cnt      <= '0;
            r_wp       <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    cht_pkg::REG_CO2_ON:   r_co2_on   <= i_cfg.data[13:0];
                    cht_pkg::REG_CO2_OFF:  r_co2_off  <= i_cfg.data[13:0];
                    cht_pkg::REG_TEMP_ON:  r_temp_on  <= $signed(i_cfg.data[14:0]);
                    cht_pkg::REG_TEMP_OFF: r_temp_off <= $signed(i_cfg.data[14:0]);
                    default: begin
                    end
                endcase
            end
            if ((accept && (cnt_nx < CW'(cht_pkg::MIN_SAMPLES)))
                    || ((r_state == cht_pkg::ST_DIVW) && div_stat.done)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (accept) begin
                r_vent <= vent_nx;
                r_ac   <= ac_nx;
                r_cnt  <= cnt_nx;
                r_wp   <= wp_nx;
                if (cnt_nx < CW'(cht_pkg::MIN_SAMPLES)) begin
                    r_ovent <= vent_nx;
                    r_oac   <= ac_nx;
                    r_opv   <= 1'b0;
                    r_opc   <= '0;
                end
            end
            if ((r_state == cht_pkg::ST_DIVW) && div_stat.done) begin
                r_ovent <= r_vent;
                r_oac   <= r_ac;
                r_opv   <= 1'b1;
                r_opc   <= div_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n  <= cnt_nx;
            r_ra <= start_s[AW-1:0];
            r_k  <= '0;
            r_sy <= '0;
            r_q  <= '0;
        end
        unique case (r_state)
            cht_pkg::ST_WALK: begin
                r_ra <= (r_ra == AW'(WINDOW - 1)) ? '0 : r_ra + 1'b1;
                r_k  <= r_k + 1'b1;
                if (r_k != '0) begin
                    r_sy <= sy_new;
                    if (r_k < r_n) begin
                        r_q <= r_q + QW'(sy_new);
                    end
                end
            end
            cht_pkg::ST_NN: begin
                r_sx <= NW'(mul_p[NW-1:0] >> 1);
                r_nn <= nnc;
            end
            cht_pkg::ST_DD:  r_d   <= mul_p[DW-1:0];
            cht_pkg::ST_BOT: r_bot <= mul_p[BOTW-1:0];
            cht_pkg::ST_T1:  r_num <= NUMW'(mul_p);
            cht_pkg::ST_T2:  r_num <= r_num - NUMW'(mul_p);
            cht_pkg::ST_T3:  r_top <= TOPW'(mul_p);
            cht_pkg::ST_T4:  r_top <= r_top + TOPW'(mul_p);
            default: begin
            end
        endcase
    end

    cht_window #(.DEPTH(WINDOW), .AW(AW)) u_window (
        .i_clk  (i_clk),
        .i_we   (accept && meas),
        .i_waddr(r_wp),
        .i_wdata(i_in.co2_ppm),
        .i_raddr(r_ra),
        .o_rdata(rdata)
    );

    cht_mul #(.AW(MAW), .BW(MBW)) u_mul (
        .i_clk(i_clk),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (mul_p)
    );

    cht_div #(.TW(TOPW), .BW(BOTW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_top  (r_top),
        .i_bot  (r_bot),
        .o_stat (div_stat),
        .o_q    (div_q)
    );

    assign o_out.valid            = r_ov;
    assign o_out.vent_on          = r_ovent;
    assign o_out.ac_on            = r_oac;
    assign o_out.prediction_valid = r_opv;
    assign o_out.predicted_co2    = r_opc;

    // The result register stays empty while a forecast is being computed.
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cht_pkg::ST_IDLE) |-> !r_ov)
        else $error("result held during forecast");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cnt_nx < CW'(cht_pkg::MIN_SAMPLES))) |=> (r_ov && !r_opv))
        else $error("short result not issued");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW))
        else $error("sample count overflow");

    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cht_pkg::ST_DIVW) |-> (div_stat.busy || div_stat.done))
        else $error("divider idle while awaited");

    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cht_pkg::ST_DIVW) && div_stat.done) |=> (r_ov && r_opv))
        else $error("forecast result not issued");
endmodule

>>> rtl/cht_window.sv
// Circular sample memory holding the most recent CO2 readings.
module cht_window #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [13:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [13:0]   o_rdata
);
    logic [13:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/cht_mul.sv
// Shared registered signed multiplier.
module cht_mul #(
    parameter int AW = 28,
    parameter int BW = 17
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

>>> rtl/cht_div.sv
// Iterative restoring divider giving a clamped and saturated 16-bit quotient.
module cht_div #(
    parameter int TW = 41,
    parameter int BW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [TW-1:0] i_top,
    input  logic        [BW-1:0] i_bot,
    output cht_pkg::t_div_stat   o_stat,
    output logic        [15:0]   o_q
);
    localparam int QB   = cht_pkg::Q_BITS;
    localparam int CMPW = ((TW > BW + QB) ? TW : BW + QB) + 1;
    localparam int CNTW = $clog2(QB + 1);

    logic [TW-2:0]   top_u;
    logic            hi_sat;
    logic [BW:0]     trial;
    logic            fits;
    logic [BW-1:0]   r_rem;
    logic [QB-1:0]   r_sh;
    logic [QB-1:0]   r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    assign top_u  = i_top[TW-2:0];
    assign hi_sat = CMPW'(top_u) >= (CMPW'(i_bot) << QB);
    assign trial  = {r_rem, r_sh[QB-1]};
    assign fits   = trial >= {1'b0, i_bot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= (i_start && (i_top[TW-1] || hi_sat))
                   || (!i_start && r_busy && (r_cnt == CNTW'(1)));
            if (i_start) begin
                if (i_top[TW-1]) begin
                    r_q    <= '0;
                end else if (hi_sat) begin
                    r_q    <= '1;
                end else begin
                    r_rem  <= BW'(top_u >> QB);
                    r_sh   <= top_u[QB-1:0];
                    r_q    <= '0;
                    r_cnt  <= CNTW'(QB);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? BW'(trial - {1'b0, i_bot}) : trial[BW-1:0];
                r_q   <= {r_q[QB-2:0], fits};
                r_sh  <= {r_sh[QB-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q = (r_q > QB'(16'hFFFF)) ? 16'hFFFF : r_q[15:0];
endmodule
